// ===== rtl/core/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and codes for the string edit distance block.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIST_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_PROCESS = 2'd1,
    OP_FINISH  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FIRST_LONG  = 2'd1,
    ST_SECOND_LONG = 2'd2,
    ST_MISORDER    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [CHAR_W-1:0] ch;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    status_e           status;
  } result_t;

  // wavefront token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } tok_t;

endpackage

// ===== rtl/core/string_edit_distance_top.sv =====
// ----------------------------------------------------------------------------
// string_edit_distance_top
// Levenshtein distance between two byte strings over a systolic cell chain.
// ----------------------------------------------------------------------------
// Usage: load the first string with append transactions, then stream the
// second string with process transactions, then issue a finish transaction.
// Append and process transactions are taken every cycle; busy_o stays low
// while they stream. A finish raises busy_o until the wavefront of the last
// second-string char has reached cell first_length, then strobes done_o for
// one cycle with the result and clears the block. The receiver cannot stall,
// so result_o must be captured on the done_o cycle.
// ----------------------------------------------------------------------------
module string_edit_distance_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sed_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             done_o,
  output sed_pkg::result_t result_o
);
  import sed_pkg::*;

  // cost and length width: holds 0..MAX_LEN
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  // ---- control state ----
  logic [CW-1:0] flen_q, slen_q, drain_q;
  status_e       err_q;
  logic          pending_q;
  logic          done_q;
  result_t       result_q;

  // entry stage of the chain
  tok_t          tok0_q;
  logic [CW-1:0] left0_q, diag0_q;

  // chain wiring; index 0 is the entry stage / row zero of the column
  tok_t          tok_w  [0:MAX_LEN];
  logic [CW-1:0] left_w [0:MAX_LEN];
  logic [CW-1:0] diag_w [0:MAX_LEN];
  logic [CW-1:0] cost_w [0:MAX_LEN];

  logic          accept, acc_app, acc_proc, acc_fin;
  logic          app_ok, proc_ok, emit;
  logic [CW-1:0] dist_raw;
  logic [DIST_W-1:0] dist_sat;

  assign busy_o  = pending_q;
  assign accept  = start_i && !pending_q;
  assign acc_app  = accept && (item_i.op == OP_APPEND);
  assign acc_proc = accept && (item_i.op == OP_PROCESS);
  assign acc_fin  = accept && (item_i.op == OP_FINISH);

  // append is dropped once the second string has begun or first is full
  assign app_ok  = acc_app && (slen_q == '0) && (flen_q != CW'(MAX_LEN));
  assign proc_ok = acc_proc && (slen_q != CW'(MAX_LEN));

  // result is taken once the last wavefront has passed cell first_length
  assign emit = pending_q && (drain_q == '0);

  assign tok_w[0]  = tok0_q;
  assign left_w[0] = left0_q;
  assign diag_w[0] = diag0_q;
  // row zero of the column equals the count of second-string chars
  assign cost_w[0] = slen_q;

  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    sed_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (emit),
      .load_i    (app_ok && (flen_q == CW'(i - 1))),
      .load_ch_i (item_i.ch),
      .tok_i     (tok_w[i-1]),
      .left_i    (left_w[i-1]),
      .diag_i    (diag_w[i-1]),
      .tok_o     (tok_w[i]),
      .left_o    (left_w[i]),
      .diag_o    (diag_w[i]),
      .cost_o    (cost_w[i])
    );
  end

  // distance read from cell first_length, saturated to the output width
  always_comb begin
    dist_raw = cost_w[flen_q];
    if (32'(dist_raw) > 32'd127) begin
      dist_sat = {DIST_W{1'b1}};
    end else begin
      dist_sat = DIST_W'(dist_raw);
    end
  end

  // entry stage payload: left is the new row zero, diag the old one
  always_ff @(posedge clk_i) begin
    if (proc_ok) begin
      left0_q <= slen_q + CW'(1);
      diag0_q <= slen_q;
    end
    if (emit) begin
      result_q.distance <= dist_sat;
      result_q.status   <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q       <= '0;
      slen_q       <= '0;
      drain_q      <= '0;
      err_q        <= ST_OK;
      pending_q    <= 1'b0;
      done_q       <= 1'b0;
      tok0_q.valid <= 1'b0;
      tok0_q.ch    <= '0;
    end else begin
      done_q       <= emit;
      tok0_q.valid <= proc_ok;
      if (proc_ok) begin
        tok0_q.ch <= item_i.ch;
      end

      if (emit) begin
        // finish: back to the reset state
        flen_q       <= '0;
        slen_q       <= '0;
        drain_q      <= '0;
        err_q        <= ST_OK;
        pending_q    <= 1'b0;
        tok0_q.valid <= 1'b0;
      end else begin
        if (app_ok) begin
          flen_q <= flen_q + CW'(1);
        end
        if (proc_ok) begin
          slen_q  <= slen_q + CW'(1);
          // the wavefront reaches cell first_length as drain_q counts down to zero
          drain_q <= flen_q;
        end else if (drain_q != '0) begin
          drain_q <= drain_q - CW'(1);
        end
        if (acc_fin) begin
          pending_q <= 1'b1;
        end
        // only the first error is kept
        if (err_q == ST_OK) begin
          if (acc_app && (slen_q != '0)) begin
            err_q <= ST_MISORDER;
          end else if (acc_app && (flen_q == CW'(MAX_LEN))) begin
            err_q <= ST_FIRST_LONG;
          end else if (acc_proc && !proc_ok) begin
            err_q <= ST_SECOND_LONG;
          end
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== rtl/core/sed_cell.sv =====
// ----------------------------------------------------------------------------
// sed_cell
// One row of the DP column: holds a first-string char and its cost.
// ----------------------------------------------------------------------------
module sed_cell #(
  parameter int unsigned IDX = 1,
  parameter int unsigned CW  = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        load_i,
  input  logic [sed_pkg::CHAR_W-1:0]  load_ch_i,
  input  sed_pkg::tok_t               tok_i,
  input  logic [CW-1:0]               left_i,
  input  logic [CW-1:0]               diag_i,
  output sed_pkg::tok_t               tok_o,
  output logic [CW-1:0]               left_o,
  output logic [CW-1:0]               diag_o,
  output logic [CW-1:0]               cost_o
);
  import sed_pkg::*;

  logic [CHAR_W-1:0] ch_q;
  logic [CW-1:0]     cost_q;
  tok_t              tok_q;
  logic [CW-1:0]     left_q, diag_q;
  logic [CW:0]       up_inc, left_inc, diag_add, best_a, best_b;
  logic [CW-1:0]     new_cost;

  always_comb begin
    up_inc   = {1'b0, cost_q} + {{CW{1'b0}}, 1'b1};
    left_inc = {1'b0, left_i} + {{CW{1'b0}}, 1'b1};
    diag_add = {1'b0, diag_i} + {{CW{1'b0}}, (ch_q != tok_i.ch)};
    best_a   = (left_inc < up_inc) ? left_inc : up_inc;
    best_b   = (diag_add < best_a) ? diag_add : best_a;
    new_cost = best_b[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ch_q <= load_ch_i;
    end
    left_q <= new_cost;
    diag_q <= cost_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q      <= CW'(IDX);
      tok_q.valid <= 1'b0;
      tok_q.ch    <= '0;
    end else if (clear_i) begin
      cost_q      <= CW'(IDX);
      tok_q.valid <= 1'b0;
    end else begin
      if (tok_i.valid) begin
        cost_q <= new_cost;
      end
      tok_q <= tok_i;
    end
  end

  assign tok_o  = tok_q;
  assign left_o = left_q;
  assign diag_o = diag_q;
  assign cost_o = cost_q;

endmodule
